// ===== src/pmst_pkg.sv =====
// Shared types and constants for the dense Prim spanning tree block.
package pmst_pkg;

    localparam int VTX_BITS       = 7;
    localparam int IN_WEIGHT_BITS = 16;

    localparam logic [VTX_BITS-1:0] MIN_VERTICES = 7'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_RUN   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_INIT,
        ST_RELAX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [VTX_BITS-1:0] edge_from;
        logic [VTX_BITS-1:0] edge_to;
        logic                last;
        logic                disconnected;
    } t_result;

endpackage

// ===== src/prim_mst_dense.sv =====
// Write item: one per cycle while idle, stored in the weight matrix at the accepting edge.
// Run item: the first edge comes from a full matrix scan (one read a cycle); each further
// edge takes a pass over the vertices and a hand-over, plus an extra pass for the second.
// A finished item waits in an output register while the next one is worked on.
// After reset the matrix is cleared one entry a cycle, (2**clog2(MAX_VERTICES))**2 entries,
// 4096 at the defaults; no item is accepted during the sweep; configuration writes are taken.
module prim_mst_dense import pmst_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // row_vertex[6:0], col_vertex[13:7], weight[29:14]
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // edge_from[6:0], edge_to[13:7]
    output logic [0:0]  m_axis_tuser,   // disconnected[0]
    output logic        m_axis_tlast
);

    localparam int VAW = $clog2(MAX_VERTICES);

    logic [VTX_BITS-1:0]        r_vertex_count;
    logic                       r_m_valid;
    t_result                    r_m_res;

    logic                       res_valid, res_ready;
    t_result                    res;
    logic                       clr_busy;
    logic                       mwr_en, mrd_en, nrd_en, nwr_en;
    logic [2*VAW-1:0]           mwr_addr, mrd_addr;
    logic [WEIGHT_BITS-1:0]     mwr_data, mrd_data;
    logic [VAW-1:0]             nrd_addr, nwr_addr;
    logic [VAW+WEIGHT_BITS-1:0] nrd_data, nwr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= MIN_VERTICES;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_res.edge_to, r_m_res.edge_from};
    assign m_axis_tuser  = r_m_res.disconnected;
    assign m_axis_tlast  = r_m_res.last;

    pmst_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (r_vertex_count),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_req_type     (s_axis_tuser[0]),
        .i_row_vertex   (s_axis_tdata[6:0]),
        .i_col_vertex   (s_axis_tdata[13:7]),
        .i_weight       (s_axis_tdata[29:14]),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .i_clr_busy     (clr_busy),
        .o_mwr_en       (mwr_en),
        .o_mwr_addr     (mwr_addr),
        .o_mwr_data     (mwr_data),
        .o_mrd_en       (mrd_en),
        .o_mrd_addr     (mrd_addr),
        .i_mrd_data     (mrd_data),
        .o_nrd_en       (nrd_en),
        .o_nrd_addr     (nrd_addr),
        .i_nrd_data     (nrd_data),
        .o_nwr_en       (nwr_en),
        .o_nwr_addr     (nwr_addr),
        .o_nwr_data     (nwr_data)
    );

    pmst_wmem #(
        .ADDR_BITS (2*VAW),
        .DATA_BITS (WEIGHT_BITS)
    ) u_wmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (mwr_en),
        .i_wr_addr  (mwr_addr),
        .i_wr_data  (mwr_data),
        .i_rd_en    (mrd_en),
        .i_rd_addr  (mrd_addr),
        .o_rd_data  (mrd_data),
        .o_clr_busy (clr_busy)
    );

    pmst_nmem #(
        .ADDR_BITS (VAW),
        .DATA_BITS (VAW + WEIGHT_BITS)
    ) u_nmem (
        .i_clk     (i_clk),
        .i_wr_en   (nwr_en),
        .i_wr_addr (nwr_addr),
        .i_wr_data (nwr_data),
        .i_rd_en   (nrd_en),
        .i_rd_addr (nrd_addr),
        .o_rd_data (nrd_data)
    );

endmodule

// ===== src/pmst_wmem.sv =====
// Weight matrix memory with a clearing sweep to the no-edge value after reset.
module pmst_wmem #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data,
    output logic                 o_clr_busy
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic                 r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '1;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

// ===== src/pmst_nmem.sv =====
// Per-vertex memory holding the nearest tree vertex and the weight of that link.
module pmst_nmem #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 22
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/pmst_core.sv =====
// Sequencer and datapath: matrix scan, nearest-vertex relaxation and result building.
module pmst_core import pmst_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [VTX_BITS-1:0]                   i_vertex_count,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic [VTX_BITS-1:0]                   i_row_vertex,
    input  logic [VTX_BITS-1:0]                   i_col_vertex,
    input  logic [IN_WEIGHT_BITS-1:0]             i_weight,
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output t_result                               o_res,
    input  logic                                  i_clr_busy,
    output logic                                  o_mwr_en,
    output logic [2*$clog2(MAX_VERTICES)-1:0]     o_mwr_addr,
    output logic [WEIGHT_BITS-1:0]                o_mwr_data,
    output logic                                  o_mrd_en,
    output logic [2*$clog2(MAX_VERTICES)-1:0]     o_mrd_addr,
    input  logic [WEIGHT_BITS-1:0]                i_mrd_data,
    output logic                                  o_nrd_en,
    output logic [$clog2(MAX_VERTICES)-1:0]       o_nrd_addr,
    input  logic [$clog2(MAX_VERTICES)+WEIGHT_BITS-1:0] i_nrd_data,
    output logic                                  o_nwr_en,
    output logic [$clog2(MAX_VERTICES)-1:0]       o_nwr_addr,
    output logic [$clog2(MAX_VERTICES)+WEIGHT_BITS-1:0] o_nwr_data
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam logic [VTX_BITS-1:0]    MAX_V   = VTX_BITS'(MAX_VERTICES);
    localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

    t_state r_state, n_state;

    logic                    r_issuing;
    logic                    r_pv;
    logic [VAW-1:0]          r_i, r_j, r_pi, r_pj;
    logic [VAW-1:0]          r_n_last, r_left;
    logic [VAW-1:0]          r_u, r_v, r_k;
    logic [VAW-1:0]          r_cand, r_cand_near;
    logic [WEIGHT_BITS-1:0]  r_best;
    logic                    r_found;
    logic                    r_tie;
    logic                    r_emit_first;
    logic [MAX_VERTICES-1:0] r_in_tree;
    t_result                 r_res;

    logic                    in_acc, run_acc, wr_ok;
    logic                    pass_st, pass_done, start_pass, issue_last;
    logic [VTX_BITS-1:0]     row_m1, col_m1, vc_m1;
    logic [VAW-1:0]          n_last_clamp;
    logic [VAW-1:0]          near_vtx;
    logic [WEIGHT_BITS-1:0]  near_key;
    logic                    relax_cond, pj_free;
    logic [VAW-1:0]          cand_near;
    logic [WEIGHT_BITS-1:0]  cand_key;

    assign in_acc  = i_in_valid && o_in_ready;
    assign run_acc = in_acc && (i_req_type == REQ_RUN);
    assign row_m1  = i_row_vertex - VTX_BITS'(1);
    assign col_m1  = i_col_vertex - VTX_BITS'(1);
    assign vc_m1   = i_vertex_count - VTX_BITS'(1);

    // Writes with a vertex of zero or above MAX_VERTICES are dropped.
    assign wr_ok = in_acc && (i_req_type == REQ_WRITE)
                && (i_row_vertex != '0) && (i_row_vertex <= MAX_V)
                && (i_col_vertex != '0) && (i_col_vertex <= MAX_V);

    assign o_mwr_en   = wr_ok;
    assign o_mwr_addr = {row_m1[VAW-1:0], col_m1[VAW-1:0]};
    assign o_mwr_data = WEIGHT_BITS'(i_weight);

    always_comb begin
        priority if (i_vertex_count < MIN_VERTICES) begin
            n_last_clamp = VAW'(1);
        end else if (i_vertex_count > MAX_V) begin
            n_last_clamp = VAW'(MAX_VERTICES - 1);
        end else begin
            n_last_clamp = vc_m1[VAW-1:0];
        end
    end

    assign pass_st    = (r_state == ST_FIRST) || (r_state == ST_INIT) || (r_state == ST_RELAX);
    assign pass_done  = pass_st && !r_issuing && !r_pv;
    assign start_pass = ((n_state == ST_FIRST) || (n_state == ST_INIT) || (n_state == ST_RELAX))
                     && (n_state != r_state);
    assign issue_last = (r_state == ST_FIRST) ? ((r_i == r_n_last) && (r_j == r_n_last))
                                              : (r_j == r_n_last);

    assign near_vtx = i_nrd_data[WEIGHT_BITS +: VAW];
    assign near_key = i_nrd_data[WEIGHT_BITS-1:0];

    // The first relaxation after the opening edge lets the second endpoint win ties.
    assign relax_cond = r_tie ? (i_mrd_data <= near_key) : (i_mrd_data < near_key);
    assign cand_near  = relax_cond ? r_k : near_vtx;
    assign cand_key   = relax_cond ? i_mrd_data : near_key;
    assign pj_free    = !r_in_tree[r_pj];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (run_acc)   n_state = ST_FIRST;
            ST_FIRST: if (pass_done) n_state = ST_EMIT;
            ST_INIT:  if (pass_done) n_state = ST_RELAX;
            ST_RELAX: if (pass_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_res_ready) begin
                    if (r_res.last) begin
                        n_state = ST_IDLE;
                    end else if (r_emit_first) begin
                        n_state = ST_INIT;
                    end else begin
                        n_state = ST_RELAX;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mrd_en    = 1'b0;
        o_nrd_en    = 1'b0;
        o_mrd_addr  = {r_i, r_j};
        unique case (r_state)
            ST_IDLE:  o_in_ready = !i_clr_busy;
            ST_FIRST: begin
                o_mrd_en   = r_issuing;
                o_mrd_addr = {r_i, r_j};
            end
            ST_INIT: begin
                o_mrd_en   = r_issuing;
                o_mrd_addr = {r_j, r_u};
            end
            ST_RELAX: begin
                o_mrd_en   = r_issuing;
                o_nrd_en   = r_issuing;
                o_mrd_addr = {r_j, r_k};
            end
            ST_EMIT:  o_res_valid = 1'b1;
            default:  o_in_ready = 1'b0;
        endcase
    end

    assign o_nrd_addr = r_j;
    assign o_nwr_en   = r_pv && ((r_state == ST_INIT)
                              || ((r_state == ST_RELAX) && pj_free && relax_cond));
    assign o_nwr_addr = r_pj;
    assign o_nwr_data = (r_state == ST_INIT) ? {r_u, i_mrd_data} : {r_k, i_mrd_data};
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issuing <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= o_mrd_en;
            if (start_pass) begin
                r_issuing <= 1'b1;
            end else if (r_issuing && issue_last) begin
                r_issuing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi <= r_i;
        r_pj <= r_j;

        if (start_pass) begin
            r_i     <= '0;
            r_j     <= '0;
            r_best  <= NO_EDGE;
            r_found <= 1'b0;
        end else begin
            if (r_issuing) begin
                if ((r_state == ST_FIRST) && (r_j == r_n_last)) begin
                    r_j <= '0;
                    r_i <= r_i + VAW'(1);
                end else begin
                    r_j <= r_j + VAW'(1);
                end
            end
            if (r_pv) begin
                // Upper triangle only; strict compare keeps the first in row-major order.
                if ((r_state == ST_FIRST) && (r_pj > r_pi) && (i_mrd_data < r_best)) begin
                    r_best  <= i_mrd_data;
                    r_u     <= r_pi;
                    r_v     <= r_pj;
                    r_found <= 1'b1;
                end
                if ((r_state == ST_RELAX) && pj_free && (cand_key < r_best)) begin
                    r_best      <= cand_key;
                    r_cand      <= r_pj;
                    r_cand_near <= cand_near;
                    r_found     <= 1'b1;
                end
            end
        end

        if (run_acc) begin
            r_n_last <= n_last_clamp;
            r_left   <= n_last_clamp - VAW'(1);
        end

        if (pass_done && (r_state == ST_FIRST)) begin
            r_emit_first <= 1'b1;
            r_k          <= r_v;
            r_tie        <= 1'b1;
            r_in_tree    <= (MAX_VERTICES'(1) << r_u) | (MAX_VERTICES'(1) << r_v);
            if (r_found) begin
                r_res.edge_from    <= VTX_BITS'(r_u) + VTX_BITS'(1);
                r_res.edge_to      <= VTX_BITS'(r_v) + VTX_BITS'(1);
                r_res.last         <= (r_left == '0);
                r_res.disconnected <= 1'b0;
            end else begin
                r_res.edge_from    <= '0;
                r_res.edge_to      <= '0;
                r_res.last         <= 1'b1;
                r_res.disconnected <= 1'b1;
            end
        end

        if (pass_done && (r_state == ST_RELAX)) begin
            r_emit_first <= 1'b0;
            r_tie        <= 1'b0;
            r_left       <= r_left - VAW'(1);
            if (r_found) begin
                r_k                <= r_cand;
                r_in_tree[r_cand]  <= 1'b1;
                r_res.edge_from    <= VTX_BITS'(r_cand) + VTX_BITS'(1);
                r_res.edge_to      <= VTX_BITS'(r_cand_near) + VTX_BITS'(1);
                r_res.last         <= (r_left == VAW'(1));
                r_res.disconnected <= 1'b0;
            end else begin
                r_res.edge_from    <= '0;
                r_res.edge_to      <= '0;
                r_res.last         <= 1'b1;
                r_res.disconnected <= 1'b1;
            end
        end
    end

    a_nmem_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nrd_en && o_nwr_en |-> o_nrd_addr != o_nwr_addr)
        else $error("nearest-vertex read and write hit the same entry");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_issuing || r_pv) |-> !o_in_ready)
        else $error("item accepted while a pass is running");

    a_cand_not_in_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RELAX) && pass_done && r_found |-> !r_in_tree[r_cand])
        else $error("chosen vertex is already in the tree");

    a_emit_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(pass_done))
        else $error("result presented without a finished pass");

endmodule
